@@ design/pbmc_pkg.sv @@
// Shared types for the PBM P4 stream converter: result kinds, error codes,
// the result item layout and the bundle that the parser hands to the output queue.
// No dependencies.
package pbmc_pkg;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DIMS  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Error codes carried with an error report.
  typedef enum logic [2:0] {
    ERR_MAGIC     = 3'd0,
    ERR_NO_SEP    = 3'd1,
    ERR_BAD_NUM   = 3'd2,
    ERR_ZERO_SIZE = 3'd3,
    ERR_NO_SPACE  = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_t;

  // Characters the parser looks for.
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Width of the packed output data word (45 bits of fields, padded to bytes).
  localparam int OUT_DATA_W = 48;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel_byte;
    logic        row_end;
    logic        image_end;
    logic [15:0] image_width;
    logic [15:0] image_height;
    err_t        error_code;
    logic        last_of_run;
  } result_t;

  // Up to two results produced by one accepted input item.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ design/pbmc_out_fifo.sv @@
// Four-entry result queue that takes up to two items per cycle and gives one.
// Depends on pbmc_pkg for the result item type.
module pbmc_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  pbmc_pkg::push_t   push,
  input  logic              pop_ready,
  output pbmc_pkg::result_t head,
  output logic              head_valid,
  output logic              room_for_two
);
  import pbmc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  result_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_plus1;

  assign head_valid   = (count_r != '0);
  assign head         = mem_r[rd_ptr_r];
  assign room_for_two = (count_r <= (PTR_W + 1)'(DEPTH - 2));
  assign pop          = head_valid && pop_ready;
  assign wr_ptr_plus1 = wr_ptr_r + PTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; the second item of a pair lands one slot further on.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_plus1] <= push.r1;
    end
  end

endmodule

@@ design/pbmc_parser.sv @@
// Header parser and pixel converter: holds the parse state and forms the
// results of each accepted byte in one pass. Depends on pbmc_pkg.
module pbmc_parser #(
  parameter int DIM_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic [7:0]      in_byte,
  input  logic            in_eof,
  output pbmc_pkg::push_t push
);
  import pbmc_pkg::*;

  localparam int ACC_W = DIM_BITS + 4;
  localparam int STR_W = DIM_BITS - 2;
  localparam int COL_W = DIM_BITS - 3;

  typedef enum logic [7:0] {
    PH_P    = 8'b0000_0001,
    PH_FOUR = 8'b0000_0010,
    PH_SEPW = 8'b0000_0100,
    PH_W    = 8'b0000_1000,
    PH_SEPH = 8'b0001_0000,
    PH_H    = 8'b0010_0000,
    PH_PIX  = 8'b0100_0000,
    PH_IDLE = 8'b1000_0000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                comment_r, comment_nxt;
  logic                sep_r, sep_nxt;
  logic [DIM_BITS-1:0] acc_r, acc_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;

  logic                is_ws, is_digit;
  logic [ACC_W-1:0]    acc_sum;
  logic                acc_over;
  logic [DIM_BITS:0]   width_plus7;
  logic [STR_W-1:0]    stride;
  logic [STR_W-1:0]    col_inc;
  logic [DIM_BITS:0]   row_inc;
  logic                row_last;
  logic [7:0]          reversed;
  logic [7:0]          pad_mask;
  logic [DIM_BITS+15:0] width_ext, height_ext;
  logic                prim_vld;
  result_t             prim;
  logic                eof_vld;
  result_t             eof_res;

  // Byte classes.
  assign is_ws    = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

  // Decimal accumulate: acc * 10 + digit, with the overflow past the bound.
  assign acc_sum  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + ACC_W'(in_byte[3:0]);
  assign acc_over = (acc_sum[ACC_W-1:DIM_BITS] != '0);

  // Row geometry for the bitmap.
  assign width_plus7 = {1'b0, width_r} + (DIM_BITS + 1)'(7);
  assign stride      = width_plus7[DIM_BITS:3];
  assign col_inc     = {1'b0, col_r} + STR_W'(1);
  assign row_last    = (col_inc == stride);
  assign row_inc     = {1'b0, row_r} + (DIM_BITS + 1)'(1);

  // Pixel i of the file byte goes to bit i; padding past the width is cleared.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      reversed[i] = in_byte[7 - i];
    end
    pad_mask = 8'hFF;
    if (row_last && (width_r[2:0] != 3'd0)) begin
      pad_mask = (8'd1 << width_r[2:0]) - 8'd1;
    end
  end

  assign width_ext  = {16'd0, width_r};
  assign height_ext = {16'd0, acc_r};

  // Next state and results of the accepted byte.
  always_comb begin
    phase_nxt   = phase_r;
    comment_nxt = comment_r;
    sep_nxt     = sep_r;
    acc_nxt     = acc_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    prim_vld    = 1'b0;
    prim        = '0;
    prim.kind   = KIND_ERROR;

    unique case (phase_r)
      PH_P: begin
        if (in_byte == CH_P) begin
          phase_nxt = PH_FOUR;
        end else begin
          prim_vld        = 1'b1;
          prim.error_code = ERR_MAGIC;
          phase_nxt       = PH_IDLE;
        end
      end
      PH_FOUR: begin
        if (in_byte == CH_FOUR) begin
          phase_nxt   = PH_SEPW;
          comment_nxt = 1'b0;
          sep_nxt     = 1'b0;
        end else begin
          prim_vld        = 1'b1;
          prim.error_code = ERR_MAGIC;
          phase_nxt       = PH_IDLE;
        end
      end
      PH_SEPW, PH_SEPH: begin
        if (comment_r) begin
          if (in_byte == CH_LF) begin
            comment_nxt = 1'b0;
          end
        end else if (is_ws) begin
          sep_nxt = 1'b1;
        end else if (in_byte == CH_HASH) begin
          comment_nxt = 1'b1;
          sep_nxt     = 1'b1;
        end else if (is_digit && sep_r) begin
          acc_nxt   = DIM_BITS'(in_byte[3:0]);
          phase_nxt = (phase_r == PH_SEPW) ? PH_W : PH_H;
        end else begin
          prim_vld        = 1'b1;
          prim.error_code = sep_r ? ERR_BAD_NUM : ERR_NO_SEP;
          phase_nxt       = PH_IDLE;
        end
      end
      PH_W: begin
        if (is_digit) begin
          if (acc_over) begin
            prim_vld        = 1'b1;
            prim.error_code = ERR_BAD_NUM;
            phase_nxt       = PH_IDLE;
          end else begin
            acc_nxt = acc_sum[DIM_BITS-1:0];
          end
        end else begin
          // Width done; this byte opens the separator run before the height.
          width_nxt   = acc_r;
          comment_nxt = 1'b0;
          sep_nxt     = 1'b0;
          if (is_ws) begin
            phase_nxt = PH_SEPH;
            sep_nxt   = 1'b1;
          end else if (in_byte == CH_HASH) begin
            phase_nxt   = PH_SEPH;
            comment_nxt = 1'b1;
            sep_nxt     = 1'b1;
          end else begin
            prim_vld        = 1'b1;
            prim.error_code = ERR_NO_SEP;
            phase_nxt       = PH_IDLE;
          end
        end
      end
      PH_H: begin
        if (is_digit) begin
          if (acc_over) begin
            prim_vld        = 1'b1;
            prim.error_code = ERR_BAD_NUM;
            phase_nxt       = PH_IDLE;
          end else begin
            acc_nxt = acc_sum[DIM_BITS-1:0];
          end
        end else begin
          height_nxt = acc_r;
          prim_vld   = 1'b1;
          if (!is_ws) begin
            prim.error_code = ERR_NO_SPACE;
            phase_nxt       = PH_IDLE;
          end else if ((width_r == '0) || (acc_r == '0)) begin
            prim.error_code = ERR_ZERO_SIZE;
            phase_nxt       = PH_IDLE;
          end else begin
            prim.kind         = KIND_DIMS;
            prim.image_width  = width_ext[15:0];
            prim.image_height = height_ext[15:0];
            phase_nxt         = PH_PIX;
            col_nxt           = '0;
            row_nxt           = '0;
          end
        end
      end
      PH_PIX: begin
        prim_vld        = 1'b1;
        prim.kind       = KIND_PIXEL;
        prim.pixel_byte = reversed & pad_mask;
        if (row_last) begin
          col_nxt      = '0;
          row_nxt      = row_inc[DIM_BITS-1:0];
          prim.row_end = 1'b1;
          if (row_inc >= {1'b0, height_r}) begin
            prim.image_end = 1'b1;
            phase_nxt      = PH_IDLE;
          end
        end else begin
          col_nxt = col_inc[COL_W-1:0];
        end
      end
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // End of file: report truncation if the image is unfinished, then re-arm.
    eof_vld            = 1'b0;
    eof_res            = '0;
    eof_res.kind       = KIND_ERROR;
    eof_res.error_code = ERR_TRUNCATED;
    if (in_eof) begin
      eof_vld     = (phase_nxt != PH_IDLE);
      phase_nxt   = PH_P;
      comment_nxt = 1'b0;
      sep_nxt     = 1'b0;
    end
  end

  // Order the results and mark the last one of this byte.
  always_comb begin
    push    = '0;
    push.r1 = eof_res;
    push.r1.last_of_run = 1'b1;
    if (in_accept) begin
      if (prim_vld) begin
        push.r0             = prim;
        push.r0.last_of_run = !eof_vld;
        push.count          = eof_vld ? 2'd2 : 2'd1;
      end else if (eof_vld) begin
        push.r0    = push.r1;
        push.count = 2'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_P;
      comment_r <= 1'b0;
      sep_r     <= 1'b0;
      acc_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      comment_r <= comment_nxt;
      sep_r     <= sep_nxt;
      acc_r     <= acc_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

@@ design/pbm_p4_stream_converter_core.sv @@
// PBM P4 stream converter top level: byte stream in, pixel, dimension and
// error items out. Each accepted byte's results are registered in the result queue.
// A byte is taken every cycle while the queue has room for two items.
// Input ready depends only on the fill of the four-entry result queue.
// Synchronous active-low reset returns the parser to the magic check, empties the queue.
// Depends on pbmc_pkg, pbmc_parser and pbmc_out_fifo.
module pbm_p4_stream_converter_core #(
  parameter int DIM_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: in_byte[7:0]
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: pixel_byte[7:0], row_end[8], image_end[9], image_width[25:10],
  //            image_height[41:26], error_code[44:42], zero pad[47:45]
  output logic [pbmc_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: kind[1:0]
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready
);
  import pbmc_pkg::*;

  push_t   push;
  result_t head;
  logic    room_for_two;
  logic    in_accept;

  assign in_tready = room_for_two;
  assign in_accept = in_tvalid && in_tready;

  // Parse state and per-byte result forming.
  pbmc_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_byte  (in_tdata),
    .in_eof   (in_tlast),
    .push     (push)
  );

  // Result queue between the parser and the output channel.
  pbmc_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pop_ready   (out_tready),
    .head        (head),
    .head_valid  (out_tvalid),
    .room_for_two(room_for_two)
  );

  // Output packing.
  assign out_tdata = {3'b000, head.error_code, head.image_height, head.image_width,
                      head.image_end, head.row_end, head.pixel_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;

endmodule

@@ bench/tb_top.sv @@
// Testbench for the PBM P4 stream converter: drives whole P4 files, noise and damaged
// files one byte per item; checks each result against the bench model or a directed row.
// Depends on pbmc_pkg and pbm_p4_stream_converter_core.
module tb_top;
  import pbmc_pkg::*;

  localparam int DIM_BITS   = 16;
  localparam int ITEM_GOAL  = 1250;
  localparam int IDLE_LIMIT = 400;
  localparam int TAIL_WAIT  = 20;

  typedef enum logic [3:0] {
    PH_MAGIC_P, PH_MAGIC_4, PH_SEP_W, PH_WIDTH, PH_SEP_H, PH_HEIGHT, PH_PIXELS, PH_IGNORE
  } phase_t;

  // One directed stimulus row; typed rows carry their single expected result.
  typedef struct packed {
    logic [7:0]  data;
    logic        eof;
    logic        typed;
    kind_t       kind;
    err_t        code;
    logic [15:0] w;
    logic [15:0] h;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [7:0]            in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // Parser model state.
  phase_t  phase = PH_MAGIC_P;
  bit      comment_open;
  bit      sep_found;
  longint  num_value;
  longint  pbm_width;
  longint  pbm_height;
  longint  col_bytes;
  longint  rows_done;

  result_t run_results[$];
  result_t pending_results[$];
  logic [7:0] file_q[$];
  int      fail_count = 0;
  int      idle_cycles = 0;

  dir_row_t dir_rows [23] = '{
    // Bad first magic byte, end of file on the same byte.
    '{8'h51, 1'b1, 1'b1, KIND_ERROR, ERR_MAGIC, 16'd0, 16'd0},
    // A 3x2 image with a comment between width and height.
    '{CH_P,     1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_FOUR,  1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_SPACE, 1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h33,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_HASH,  1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_LF,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h32,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_SPACE, 1'b0, 1'b1, KIND_DIMS,  ERR_MAGIC, 16'd3, 16'd2},
    '{8'hFF,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h80,    1'b1, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    // Digit right after the magic with no separator.
    '{CH_P,     1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_FOUR,  1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_ZERO,  1'b1, 1'b1, KIND_ERROR, ERR_NO_SEP, 16'd0, 16'd0},
    // Width one past the largest value.
    '{CH_P,     1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_FOUR,  1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{CH_TAB,   1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h36,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h35,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h35,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h33,    1'b0, 1'b0, KIND_PIXEL, ERR_MAGIC, 16'd0, 16'd0},
    '{8'h36,    1'b1, 1'b1, KIND_ERROR, ERR_BAD_NUM, 16'd0, 16'd0},
    // File that ends after its first byte.
    '{CH_P,     1'b1, 1'b1, KIND_ERROR, ERR_TRUNCATED, 16'd0, 16'd0}
  };

  pbm_p4_stream_converter_core #(
    .DIM_BITS(DIM_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #4 clk = ~clk;

  function automatic bit is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Return the model to the state it has after reset.
  task automatic clear_parser();
    phase        = PH_MAGIC_P;
    comment_open = 1'b0;
    sep_found    = 1'b0;
    num_value    = 0;
    pbm_width    = 0;
    pbm_height   = 0;
    col_bytes    = 0;
    rows_done    = 0;
  endtask

  task automatic raise_error(input err_t code);
    result_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    phase = PH_IGNORE;
    run_results.push_back(r);
  endtask

  // Separator region: whitespace and comments, ended by the first digit of a number.
  task automatic take_separator(input logic [7:0] b);
    if (comment_open) begin
      if (b == CH_LF) comment_open = 1'b0;
    end else if (is_space(b)) begin
      sep_found = 1'b1;
    end else if (b == CH_HASH) begin
      comment_open = 1'b1;
      sep_found    = 1'b1;
    end else if (is_digit(b)) begin
      if (!sep_found) begin
        raise_error(ERR_NO_SEP);
      end else begin
        num_value = b - CH_ZERO;
        phase = (phase == PH_SEP_W) ? PH_WIDTH : PH_HEIGHT;
      end
    end else begin
      raise_error(sep_found ? ERR_BAD_NUM : ERR_NO_SEP);
    end
  endtask

  // Decimal accumulation with the overflow bound checked on every digit.
  task automatic add_digit(input logic [7:0] b);
    longint v;
    v = num_value * 10 + (b - CH_ZERO);
    if (v > (64'd1 << DIM_BITS) - 1) raise_error(ERR_BAD_NUM);
    else num_value = v;
  endtask

  // Bitmap byte: reverse bit order, clear padding past the width, mark row and image ends.
  task automatic take_pixel(input logic [7:0] b);
    longint  stride;
    longint  valid;
    int      mask;
    result_t r;
    stride = (pbm_width + 7) >> 3;
    r = '0;
    r.kind = KIND_PIXEL;
    for (int i = 0; i < 8; i++) r.pixel_byte[i] = b[7-i];
    if (col_bytes + 1 == stride) begin
      valid = pbm_width - col_bytes * 8;
      if (valid < 8) begin
        mask = (1 << valid) - 1;
        r.pixel_byte = r.pixel_byte & mask[7:0];
      end
    end
    col_bytes++;
    if (col_bytes >= stride) begin
      col_bytes = 0;
      r.row_end = 1'b1;
      rows_done++;
      if (rows_done >= pbm_height) begin
        r.image_end = 1'b1;
        phase = PH_IGNORE;
      end
    end
    run_results.push_back(r);
  endtask

  // Work out the results that one accepted byte causes, in run_results.
  task automatic parse_byte(input logic [7:0] b, input logic eof);
    result_t r;
    run_results.delete();
    case (phase)
      PH_MAGIC_P: begin
        if (b == CH_P) phase = PH_MAGIC_4;
        else raise_error(ERR_MAGIC);
      end
      PH_MAGIC_4: begin
        if (b == CH_FOUR) begin
          phase        = PH_SEP_W;
          comment_open = 1'b0;
          sep_found    = 1'b0;
        end else begin
          raise_error(ERR_MAGIC);
        end
      end
      PH_SEP_W, PH_SEP_H: take_separator(b);
      PH_WIDTH: begin
        if (is_digit(b)) begin
          add_digit(b);
        end else begin
          pbm_width    = num_value;
          phase        = PH_SEP_H;
          comment_open = 1'b0;
          sep_found    = 1'b0;
          take_separator(b);
        end
      end
      PH_HEIGHT: begin
        if (is_digit(b)) begin
          add_digit(b);
        end else begin
          pbm_height = num_value;
          if (!is_space(b)) begin
            raise_error(ERR_NO_SPACE);
          end else if (pbm_width == 0 || pbm_height == 0) begin
            raise_error(ERR_ZERO_SIZE);
          end else begin
            r = '0;
            r.kind         = KIND_DIMS;
            r.image_width  = pbm_width[15:0];
            r.image_height = pbm_height[15:0];
            run_results.push_back(r);
            phase     = PH_PIXELS;
            col_bytes = 0;
            rows_done = 0;
          end
        end
      end
      PH_PIXELS: take_pixel(b);
      default: ;
    endcase
    if (eof) begin
      if (phase != PH_IGNORE) raise_error(ERR_TRUNCATED);
      clear_parser();
    end
    if (run_results.size() > 0) run_results[run_results.size()-1].last_of_run = 1'b1;
  endtask

  task automatic queue_run_results();
    foreach (run_results[j]) pending_results.push_back(run_results[j]);
  endtask

  // Offer one item after an idle gap and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic eof, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
  endtask

  // Separator run: whitespace bytes and comments up to a newline.
  task automatic push_separator();
    int          count;
    int          clen;
    logic [7:0]  c;
    logic [7:0]  spaces [6];
    spaces = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
    count = $urandom_range(1, 3);
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) begin
        file_q.push_back(spaces[$urandom_range(0, 5)]);
      end else begin
        file_q.push_back(CH_HASH);
        clen = $urandom_range(0, 4);
        repeat (clen) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_LF) c = 8'h41;
          file_q.push_back(c);
        end
        file_q.push_back(CH_LF);
      end
    end
  endtask

  task automatic push_number(input int value);
    string s;
    s = $sformatf("%0d", value);
    if ($urandom_range(0, 7) == 0) file_q.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  // Mostly small sizes; now and then zero, the largest value, large or past the bound.
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return (1 << DIM_BITS) - 1;
    if (r < 14) return $urandom_range(256, (1 << DIM_BITS) - 1);
    if (r < 18) return $urandom_range(1 << DIM_BITS, 99999);
    return $urandom_range(1, 24);
  endfunction

  // Build one file: a P4 image, a damaged image, or plain noise.
  task automatic build_file();
    int style;
    int damage;
    int w;
    int h;
    int npix;
    int final_ws;
    int width_at;
    int cut;
    file_q.delete();
    style  = $urandom_range(0, 99);
    damage = (style >= 10 && style < 40) ? $urandom_range(0, 4) : -1;
    if (style < 10) begin
      npix = $urandom_range(1, 6);
      repeat (npix) file_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      w = pick_dim();
      h = pick_dim();
      file_q.push_back(CH_P);
      file_q.push_back(CH_FOUR);
      if (damage != 2) push_separator();
      width_at = file_q.size();
      push_number(w);
      push_separator();
      push_number(h);
      final_ws = file_q.size();
      file_q.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_LF);
      npix = ((w + 7) / 8) * h;
      if (npix > 300) npix = $urandom_range(0, 12);
      repeat (npix) file_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 255)));
      end
      case (damage)
        0: file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
        1: begin
          cut = $urandom_range(1, file_q.size());
          while (file_q.size() > cut) void'(file_q.pop_back());
        end
        3: file_q[final_ws] = ($urandom_range(0, 1) == 0) ? CH_HASH
                                                          : 8'($urandom_range(8'h41, 8'h5A));
        4: file_q.insert(width_at, 8'($urandom_range(8'h41, 8'h5A)));
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result monitor: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: kind %0d, data %h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("pixel_byte", want.pixel_byte, out_tdata[7:0]);
        check_field("row_end", want.row_end, out_tdata[8]);
        check_field("image_end", want.image_end, out_tdata[9]);
        check_field("image_width", want.image_width, out_tdata[25:10]);
        check_field("image_height", want.image_height, out_tdata[41:26]);
        check_field("error_code", want.error_code, out_tdata[44:42]);
        check_field("last_of_run", want.last_of_run, out_tlast);
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result sink with random stalls, alternating with stretches of none.
  initial begin : result_sink
    int stall;
    int mode_left;
    bit no_stall;
    mode_left = 0;
    no_stall  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        no_stall  = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      stall = no_stall ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Reset, the directed table, then random files until enough items have gone in.
  initial begin : stimulus
    result_t r;
    int      items_sent;
    bit      no_gaps;
    clear_parser();
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].eof, $urandom_range(0, 10));
      parse_byte(dir_rows[i].data, dir_rows[i].eof);
      if (dir_rows[i].typed) begin
        r = '0;
        r.kind         = dir_rows[i].kind;
        r.error_code   = dir_rows[i].code;
        r.image_width  = dir_rows[i].w;
        r.image_height = dir_rows[i].h;
        r.last_of_run  = 1'b1;
        pending_results.push_back(r);
      end else begin
        queue_run_results();
      end
    end

    while (items_sent < ITEM_GOAL) begin
      build_file();
      no_gaps = ($urandom_range(0, 3) == 0);
      foreach (file_q[i]) begin
        send_byte(file_q[i], i == file_q.size() - 1, no_gaps ? 0 : $urandom_range(0, 10));
        parse_byte(file_q[i], i == file_q.size() - 1);
        queue_run_results();
      end
      items_sent += file_q.size();
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
